// ----- sv/i2cm_pkg.sv -----
// i2cm_pkg: shared types and constants for the i2c master byte engine
// no dependencies; used by every module of the block
package i2cm_pkg;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_WAIT  = 3'd5
  } cmd_t;

  typedef enum logic [0:0] {
    CFG_ACK_LIMIT   = 1'b0,
    CFG_PHASE_TICKS = 1'b1
  } cfg_idx_t;

  localparam logic [7:0] ACK_LIMIT_RST   = 8'd250;
  localparam logic [7:0] PHASE_TICKS_RST = 8'd1;
  localparam logic [7:0] POLL_MAX        = 8'hff;
  localparam logic [3:0] BITS_PER_BYTE   = 4'd8;
  localparam logic [3:0] POLL_PHASE      = 4'd2;

  typedef struct packed {
    logic [7:0] ack_limit;
    logic [7:0] phase_ticks;
  } cfg_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [3:0] phase;
    logic [3:0] bit_idx;
    logic [7:0] shift;
    logic [7:0] tick;
    logic [7:0] poll;
    logic       ack_choice;
    logic       scl;
    logic       sda;
    logic       fail;
    logic [7:0] rx_hold;
  } seq_state_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_data;
    logic       ack_failed;
  } result_t;

endpackage

// ----- sv/i2cm_in_if.sv -----
// i2cm_in_if: tick channel into the i2c master, valid/ready plus command fields
// depends on nothing but the standard handshake convention
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] tx_data;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, output action, output tx_data, output send_ack,
                  output sda_in, input ready);
  modport sink   (input valid, input action, input tx_data, input send_ack,
                  input sda_in, output ready);
endinterface

// ----- sv/i2cm_out_if.sv -----
// i2cm_out_if: result channel of the i2c master, valid/ready plus pin and status fields
// depends on nothing but the standard handshake convention
interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_data;
  logic       ack_failed;

  modport source (output valid, output scl_out, output sda_out, output busy_res,
                  output done_res, output rx_data, output ack_failed, input ready);
  modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                  input done_res, input rx_data, input ack_failed, output ready);
endinterface

// ----- sv/i2cm_seq.sv -----
// i2cm_seq: next-state logic of the bus sequencer for one tick, plus the result it yields
// depends on i2cm_pkg
module i2cm_seq (
  input  i2cm_pkg::seq_state_t cur,
  input  i2cm_pkg::cfg_t       cfg,
  input  logic [2:0]           action,
  input  logic [7:0]           tx_data,
  input  logic                 send_ack,
  input  logic                 sda_in,
  output i2cm_pkg::seq_state_t nxt,
  output i2cm_pkg::result_t    res
);

  // pin writes that open the segment named by s.phase
  function automatic i2cm_pkg::seq_state_t enter_seg(i2cm_pkg::seq_state_t s);
    i2cm_pkg::seq_state_t r;
    r = s;
    unique case (s.cmd)
      i2cm_pkg::CMD_START: begin
        if (s.phase == 4'd0) begin
          r.sda = 1'b1;
          r.scl = 1'b1;
        end else if (s.phase == 4'd1) begin
          r.sda = 1'b0;
        end else begin
          r.scl = 1'b0;
        end
      end
      i2cm_pkg::CMD_STOP: begin
        if (s.phase == 4'd0) r.sda = 1'b0;
        else if (s.phase == 4'd1) r.scl = 1'b1;
        else r.sda = 1'b1;
      end
      i2cm_pkg::CMD_WRITE: begin
        if (s.phase == 4'd0) begin
          if (s.bit_idx != 4'd0) r.scl = 1'b0;
          r.sda = s.shift[7];
        end else begin
          r.scl = 1'b1;
        end
      end
      i2cm_pkg::CMD_READ: begin
        case (s.phase)
          4'd0, 4'd3: r.scl = 1'b1;
          4'd1, 4'd4: r.scl = 1'b0;
          4'd2:       r.sda = ~s.ack_choice;
          default:    r.sda = 1'b1;
        endcase
      end
      i2cm_pkg::CMD_WAIT: begin
        case (s.phase)
          4'd0, 4'd5: r.sda = 1'b1;
          4'd1, 4'd4: r.scl = 1'b1;
          4'd3:       r.sda = 1'b0;
          4'd6:       r.scl = 1'b0;
          default:    r = s;
        endcase
      end
      default: r = s;
    endcase
    return r;
  endfunction

  function automatic i2cm_pkg::seq_state_t go_to(i2cm_pkg::seq_state_t s, logic [3:0] p);
    i2cm_pkg::seq_state_t r;
    r       = s;
    r.phase = p;
    r.tick  = 8'd0;
    return enter_seg(r);
  endfunction

  logic [7:0] limit_ticks;
  logic [7:0] tick_inc;
  logic [7:0] poll_inc;
  logic [3:0] bit_inc;
  logic [3:0] phase_inc;
  logic       done;
  logic       finish;
  i2cm_pkg::seq_state_t s;

  assign limit_ticks = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
  assign tick_inc    = cur.tick + 8'd1;
  assign poll_inc    = (cur.poll == i2cm_pkg::POLL_MAX) ? cur.poll : cur.poll + 8'd1;
  assign bit_inc     = cur.bit_idx + 4'd1;
  assign phase_inc   = cur.phase + 4'd1;

  // next state
  always_comb begin
    s      = cur;
    finish = 1'b0;
    if (cur.cmd == i2cm_pkg::CMD_NONE) begin
      if (action >= 3'(i2cm_pkg::CMD_START) && action <= 3'(i2cm_pkg::CMD_WAIT)) begin
        s.cmd        = i2cm_pkg::cmd_t'(action);
        s.bit_idx    = 4'd0;
        s.poll       = 8'd0;
        s.ack_choice = send_ack;
        s.shift      = (action == 3'(i2cm_pkg::CMD_WRITE)) ? tx_data : 8'd0;
        if (action == 3'(i2cm_pkg::CMD_WAIT)) s.fail = 1'b0;
        s = go_to(s, 4'd0);
      end
    end else if (cur.cmd == i2cm_pkg::CMD_WAIT && cur.phase == i2cm_pkg::POLL_PHASE) begin
      if (!sda_in) begin
        s = go_to(s, 4'd6);
      end else begin
        s.poll = poll_inc;
        if (poll_inc > cfg.ack_limit) begin
          s.fail = 1'b1;
          s = go_to(s, 4'd3);
        end
      end
    end else if (tick_inc < limit_ticks) begin
      s.tick = tick_inc;
    end else begin
      s.tick = 8'd0;
      unique case (cur.cmd)
        i2cm_pkg::CMD_START, i2cm_pkg::CMD_STOP, i2cm_pkg::CMD_WAIT: begin
          if ((cur.cmd == i2cm_pkg::CMD_WAIT) ? (cur.phase >= 4'd6) : (cur.phase >= 4'd2))
            finish = 1'b1;
          else
            s = go_to(s, phase_inc);
        end
        i2cm_pkg::CMD_WRITE: begin
          if (cur.phase == 4'd0) begin
            s = go_to(s, 4'd1);
          end else if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
            s.scl  = 1'b0;
            s.sda  = 1'b1;
            finish = 1'b1;
          end else begin
            s.bit_idx = bit_inc;
            s.shift   = {cur.shift[6:0], 1'b0};
            s = go_to(s, 4'd0);
          end
        end
        i2cm_pkg::CMD_READ: begin
          if (cur.phase == 4'd0) begin
            s.shift = {cur.shift[6:0], sda_in};
            s = go_to(s, 4'd1);
          end else if (cur.phase == 4'd1) begin
            s.bit_idx = bit_inc;
            s = go_to(s, (bit_inc >= i2cm_pkg::BITS_PER_BYTE) ? 4'd2 : 4'd0);
          end else if (cur.phase >= (cur.ack_choice ? 4'd5 : 4'd4)) begin
            s.rx_hold = cur.shift;
            finish    = 1'b1;
          end else begin
            s = go_to(s, phase_inc);
          end
        end
        default: finish = 1'b1;
      endcase
      if (finish) begin
        s.cmd     = i2cm_pkg::CMD_NONE;
        s.phase   = 4'd0;
        s.bit_idx = 4'd0;
        s.tick    = 8'd0;
      end
    end
    nxt  = s;
    done = finish;
  end

  // result for this tick, taken from the updated state
  always_comb begin
    res.scl_out    = nxt.scl;
    res.sda_out    = nxt.sda;
    res.busy_res   = (nxt.cmd != i2cm_pkg::CMD_NONE);
    res.done_res   = done;
    res.rx_data    = nxt.rx_hold;
    res.ack_failed = nxt.fail;
  end

endmodule

// ----- sv/i2cm_out_reg.sv -----
// i2cm_out_reg: result register that decouples the tick channel from the result channel
// depends on i2cm_pkg and i2cm_out_if
module i2cm_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  i2cm_pkg::result_t res,
  output logic              room,
  i2cm_out_if.source        out_ch
);

  logic              valid_r;
  logic              valid_nxt;
  i2cm_pkg::result_t data_r;

  assign room      = !valid_r || out_ch.ready;
  assign valid_nxt = load || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.scl_out    = data_r.scl_out;
  assign out_ch.sda_out    = data_r.sda_out;
  assign out_ch.busy_res   = data_r.busy_res;
  assign out_ch.done_res   = data_r.done_res;
  assign out_ch.rx_data    = data_r.rx_data;
  assign out_ch.ack_failed = data_r.ack_failed;

endmodule

// ----- sv/i2c_master_byte_engine.sv -----
// i2c_master_byte_engine: tick-driven i2c master, top level
// depends on i2cm_pkg, i2cm_in_if, i2cm_out_if, i2cm_seq and i2cm_out_reg
//
// usage
// - in_ch carries one bus-timing tick per beat: an optional command (start, stop,
//   write byte, read byte, wait for ack), the byte to send, the ack choice for a
//   read and the sampled sda level
// - out_ch returns exactly one beat per tick: scl/sda drive, busy, done, the last
//   received byte and the ack-timeout flag, all as they stand after that tick
// - cfg_we/cfg_idx/cfg_wdata write ack_timeout_limit (index 0) and phase_ticks
//   (index 1); write only while no tick is in flight
// - latency: the result of a tick is on out_ch the cycle after its beat is taken
// - throughput: one tick per cycle while out_ch is not stalled; the sequencer step is
//   one pass of logic between the state register and the result register
// - when the receiver stalls, in_ch.ready follows: a tick is taken only if the
//   result register is empty or being emptied in the same cycle
// - synchronous reset: pins released, no command, limit 250, phase length 1 tick,
//   result register empty; no clearing pass is needed
// - a command given while busy, or an unknown action code, is ignored
module i2c_master_byte_engine (
  input  logic       clk,
  input  logic       rst_n,
  i2cm_in_if.sink    in_ch,
  i2cm_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_idx,
  input  logic [7:0] cfg_wdata
);

  // sequencer state and configuration registers
  i2cm_pkg::seq_state_t st_r;
  i2cm_pkg::seq_state_t st_nxt;
  i2cm_pkg::cfg_t       cfg_r;
  i2cm_pkg::result_t    res;
  logic                 room;
  logic                 accept;

  assign in_ch.ready = room;
  assign accept      = in_ch.valid && room;

  // register writes, decoded by index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ack_limit   <= i2cm_pkg::ACK_LIMIT_RST;
      cfg_r.phase_ticks <= i2cm_pkg::PHASE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (i2cm_pkg::cfg_idx_t'(cfg_idx))
        i2cm_pkg::CFG_ACK_LIMIT:   cfg_r.ack_limit   <= cfg_wdata;
        i2cm_pkg::CFG_PHASE_TICKS: cfg_r.phase_ticks <= cfg_wdata;
        default:                   cfg_r             <= cfg_r;
      endcase
    end
  end

  // one sequencer step per accepted tick
  i2cm_seq u_seq (
    .cur      (st_r),
    .cfg      (cfg_r),
    .action   (in_ch.action),
    .tx_data  (in_ch.tx_data),
    .send_ack (in_ch.send_ack),
    .sda_in   (in_ch.sda_in),
    .nxt      (st_nxt),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.cmd        <= i2cm_pkg::CMD_NONE;
      st_r.phase      <= 4'd0;
      st_r.bit_idx    <= 4'd0;
      st_r.shift      <= 8'd0;
      st_r.tick       <= 8'd0;
      st_r.poll       <= 8'd0;
      st_r.ack_choice <= 1'b0;
      st_r.scl        <= 1'b1;
      st_r.sda        <= 1'b1;
      st_r.fail       <= 1'b0;
      st_r.rx_hold    <= 8'd0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  // result register, one beat out per tick taken
  i2cm_out_reg u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (accept),
    .res    (res),
    .room   (room),
    .out_ch (out_ch)
  );

  // a finished command never reports busy in the same beat
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.done_res && out_ch.busy_res))
    else $error("done and busy reported together");

  // a held result blocks new ticks
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("tick taken while result stalled");

  // idle with no command stays idle
  a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
    accept && st_r.cmd == i2cm_pkg::CMD_NONE && in_ch.action == 3'(i2cm_pkg::CMD_NONE)
    |=> st_r.cmd == i2cm_pkg::CMD_NONE)
    else $error("command started without an action");

  // the failure flag is only raised during an ack wait
  a_fail_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r.fail) |-> $past(accept && st_r.cmd == i2cm_pkg::CMD_WAIT))
    else $error("ack failure outside an ack wait");

  // state only moves on an accepted tick
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(st_r))
    else $error("sequencer state changed without a tick");

endmodule
